// ----- src/rcc_pkg.sv -----
// Shared types and constants of the 3x3 RGB convolution block.
`default_nettype none
package rcc_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int COEF_W     = 16;
  localparam int KERN_DIM   = 3;
  localparam int KERN_TAPS  = KERN_DIM * KERN_DIM;
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_COEF_W = KERN_DIM * COEF_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_BOTTOM = 3'd4;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CH_W-1:0] PIX_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [KERN_DIM-1:0][CFG_COEF_W-1:0] coef_rows_t;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_of_frame;
  } pix_out_t;

  typedef struct packed {
    pixel_t [KERN_TAPS-1:0] px;
    logic                   last;
  } conv_task_t;

endpackage
`default_nettype wire

// ----- src/rcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [ADDR_W-1:0]       waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic                    re,
  input  wire logic [ADDR_W-1:0]       raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/rcc_queue.sv -----
// Small FIFO of convolution tasks between the front and the back.
`default_nettype none
module rcc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  din,
  input  wire logic              pop,
  output logic      [WIDTH-1:0]  dout,
  output logic      [CNT_W-1:0]  count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/rcc_front.sv -----
// Front end: accepts pixels, tracks position, keeps line stores and window, emits tasks.
`default_nettype none
module rcc_front import rcc_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int QUEUE_DEPTH = 4,
  localparam int QC_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pix_in_t               in_data,
  input  wire logic [CFG_DIM_W-1:0]  frame_width,
  input  wire logic [CFG_DIM_W-1:0]  frame_height,
  input  wire logic [QC_W-1:0]       q_count,
  output logic                       push,
  output conv_task_t                 push_data
);
  localparam int IC_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int IR_W  = $clog2(MAX_HEIGHT + 2);
  localparam int DIM_W = ((WD_W > IR_W) ? WD_W : IR_W) + CFG_DIM_W;
  localparam int LS_W  = 2 * PIX_W;

  logic [DIM_W-1:0] fw_x;
  logic [DIM_W-1:0] fh_x;
  logic [WD_W-1:0]  w_used;
  logic [IR_W-1:0]  h_used;
  logic             accept;
  logic [IC_W-1:0]  ic;
  logic [IR_W-1:0]  ir;
  logic             a_col0;
  logic             a_last;
  logic             a_main;
  logic [PIX_W-1:0] a_v;

  logic             b_valid;
  logic [IC_W-1:0]  b_ic;
  logic [PIX_W-1:0] b_v;
  logic             b_last;
  logic             b_col0;
  logic             b_main;
  logic             b_first;
  logic             b_wide;
  logic             b_top_en;
  logic             b_mid_en;
  logic             fwd_hit;
  logic [LS_W-1:0]  fwd_data;

  logic [LS_W-1:0]  ls_rdata;
  logic [LS_W-1:0]  ls_eff;
  logic [LS_W-1:0]  ls_wdata;
  pixel_t           top;
  pixel_t           mid;
  pixel_t [KERN_TAPS-1:0] win;
  pixel_t [KERN_TAPS-1:0] win_next;

  always_comb begin
    fw_x = DIM_W'(frame_width);
    fh_x = DIM_W'(frame_height);
    if (fw_x == '0) begin
      w_used = WD_W'(1);
    end else if (fw_x > DIM_W'(MAX_WIDTH)) begin
      w_used = WD_W'(MAX_WIDTH);
    end else begin
      w_used = WD_W'(fw_x);
    end
    if (fh_x == '0) begin
      h_used = IR_W'(1);
    end else if (fh_x > DIM_W'(MAX_HEIGHT)) begin
      h_used = IR_W'(MAX_HEIGHT);
    end else begin
      h_used = IR_W'(fh_x);
    end
  end

  // Credit check: every item in flight may still add one task to the queue.
  assign in_stall = ((QC_W + 1)'(q_count) + (QC_W + 1)'(b_valid)) >= (QC_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  assign a_col0 = (ic == '0) && (ir > IR_W'(1));
  assign a_last = a_col0 && (ir > h_used);
  assign a_main = (ic != '0) && (ir != '0) && (ir <= h_used);
  assign a_v    = (in_data.cmd == CMD_PIXEL && ir < h_used) ?
                  {in_data.red_in, in_data.green_in, in_data.blue_in} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ic      <= '0;
      ir      <= '0;
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
      if (accept) begin
        if (a_last) begin
          ic <= '0;
          ir <= '0;
        end else if ((WD_W'(ic) + WD_W'(1)) >= w_used) begin
          ic <= '0;
          ir <= IR_W'(ir + 1'b1);
        end else begin
          ic <= IC_W'(ic + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_ic     <= ic;
      b_v      <= a_v;
      b_last   <= a_last;
      b_col0   <= a_col0;
      b_main   <= a_main;
      b_first  <= (ic == IC_W'(1));
      b_wide   <= (w_used > WD_W'(1));
      b_top_en <= (ir > IR_W'(1));
      b_mid_en <= (ir != '0);
      // The write from the item ahead lands in the same cycle as this read.
      fwd_hit  <= b_valid && (b_ic == ic);
      fwd_data <= ls_wdata;
    end
  end

  // Upper half holds the older row, lower half the newer row.
  rcc_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_ic),
    .wdata (ls_wdata),
    .re    (accept),
    .raddr (ic),
    .rdata (ls_rdata)
  );

  assign ls_eff   = fwd_hit ? fwd_data : ls_rdata;
  assign ls_wdata = {ls_eff[PIX_W-1:0], b_v};
  assign top      = b_top_en ? ls_eff[LS_W-1:PIX_W] : '0;
  assign mid      = b_mid_en ? ls_eff[PIX_W-1:0] : '0;

  always_comb begin
    for (int r = 0; r < KERN_DIM; r++) begin
      win_next[r*KERN_DIM + 0] = win[r*KERN_DIM + 1];
      win_next[r*KERN_DIM + 1] = win[r*KERN_DIM + 2];
    end
    win_next[2] = top;
    win_next[5] = mid;
    win_next[8] = b_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (b_valid) begin
      win <= b_last ? '0 : win_next;
    end
  end

  assign push = b_valid && (b_col0 || b_main);

  // A row start finishes the previous row's last pixel from the old window.
  always_comb begin
    push_data.last = b_last;
    for (int r = 0; r < KERN_DIM; r++) begin
      if (b_col0) begin
        push_data.px[r*KERN_DIM + 0] = b_wide ? win[r*KERN_DIM + 1] : '0;
        push_data.px[r*KERN_DIM + 1] = win[r*KERN_DIM + 2];
        push_data.px[r*KERN_DIM + 2] = '0;
      end else begin
        push_data.px[r*KERN_DIM + 0] = b_first ? '0 : win_next[r*KERN_DIM + 0];
        push_data.px[r*KERN_DIM + 1] = win_next[r*KERN_DIM + 1];
        push_data.px[r*KERN_DIM + 2] = win_next[r*KERN_DIM + 2];
      end
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && a_last |=> (ic == '0) && (ir == '0))
    else $error("position did not return to the frame start after the last item");

  a_row_start_kind: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> !(b_col0 && b_main))
    else $error("a task was classified both as row start and in-row output");

endmodule
`default_nettype wire

// ----- src/rcc_back.sv -----
// Back end: 27 multiplies, row sums, total, truncation and clamp per channel.
`default_nettype none
module rcc_back import rcc_pkg::*; #(
  parameter int COEF_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire coef_rows_t  coef_rows,
  input  wire logic        task_avail,
  input  wire conv_task_t  task_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output pix_out_t         out_data
);
  localparam int PROD_W = COEF_W + CH_W + 1;
  localparam int ROW_W  = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  logic                     en;
  logic                     s1_valid;
  logic                     s1_last;
  logic signed [PROD_W-1:0] s1_prod [KERN_DIM][KERN_TAPS];
  logic                     s2_valid;
  logic                     s2_last;
  logic signed [ROW_W-1:0]  s2_row [KERN_DIM][KERN_DIM];
  logic signed [SUM_W-1:0]  total [KERN_DIM];
  logic signed [SUM_W-1:0]  shifted [KERN_DIM];
  logic [CH_W-1:0]          chan [KERN_DIM];

  assign en  = !out_valid || !out_stall;
  assign pop = en && task_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= task_avail;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last <= task_data.last;
      for (int ch = 0; ch < KERN_DIM; ch++) begin
        for (int k = 0; k < KERN_TAPS; k++) begin
          s1_prod[ch][k] <=
            $signed(coef_rows[k / KERN_DIM][(k % KERN_DIM)*COEF_W +: COEF_W]) *
            $signed({1'b0, task_data.px[k][PIX_W-1-CH_W*ch -: CH_W]});
        end
      end
      s2_last <= s1_last;
      for (int ch = 0; ch < KERN_DIM; ch++) begin
        for (int r = 0; r < KERN_DIM; r++) begin
          s2_row[ch][r] <= ROW_W'(s1_prod[ch][r*KERN_DIM + 0]) +
                           ROW_W'(s1_prod[ch][r*KERN_DIM + 1]) +
                           ROW_W'(s1_prod[ch][r*KERN_DIM + 2]);
        end
      end
      out_data.red_out       <= chan[0];
      out_data.green_out     <= chan[1];
      out_data.blue_out      <= chan[2];
      out_data.last_of_frame <= s2_last;
    end
  end

  // Negative sums give zero; otherwise drop the fraction and saturate.
  always_comb begin
    for (int ch = 0; ch < KERN_DIM; ch++) begin
      total[ch]   = SUM_W'(s2_row[ch][0]) + SUM_W'(s2_row[ch][1]) + SUM_W'(s2_row[ch][2]);
      shifted[ch] = total[ch] >>> COEF_FRAC_BITS;
      if (total[ch] < 0) begin
        chan[ch] = '0;
      end else if (shifted[ch] > SUM_W'(PIX_MAX)) begin
        chan[ch] = PIX_MAX;
      end else begin
        chan[ch] = shifted[ch][CH_W-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while the output was stalled");

endmodule
`default_nettype wire

// ----- src/rgb_convolution_3x3_clamped.sv -----
// Top level of the 3x3 RGB convolution with zero padding and clamping.
// Throughput: one item per clock unless in_stall or out_stall holds it back; output
// pixel k leaves with input item k + W + 1. An accepted item passes the line store read,
// window stage and queue write, multiply stage, row-sum stage and output register.
// Reset clears position counters, window, queue and pipeline valids; the line
// store RAM is not cleared and needs no clearing pass, so items are taken at once.
`default_nettype none
module rgb_convolution_3x3_clamped import rcc_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire pix_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output pix_out_t                    out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_COEF_W-1:0]  cfg_data
);
  localparam int QUEUE_DEPTH = 4;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int TASK_W      = $bits(conv_task_t);

  logic [CFG_DIM_W-1:0] frame_width;
  logic [CFG_DIM_W-1:0] frame_height;
  coef_rows_t           coef_rows;
  logic                 q_push;
  logic                 q_pop;
  conv_task_t           q_din;
  logic [TASK_W-1:0]    q_dout;
  logic [QC_W-1:0]      q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_DIM_W'(1);
      frame_height <= CFG_DIM_W'(1);
      coef_rows[0] <= '0;
      coef_rows[1] <= CFG_COEF_W'(1) << (COEF_W + COEF_FRAC_BITS);
      coef_rows[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:     frame_width  <= cfg_data[CFG_DIM_W-1:0];
        CFG_FRAME_HEIGHT:    frame_height <= cfg_data[CFG_DIM_W-1:0];
        CFG_COEF_ROW_TOP:    coef_rows[0] <= cfg_data;
        CFG_COEF_ROW_MIDDLE: coef_rows[1] <= cfg_data;
        CFG_COEF_ROW_BOTTOM: coef_rows[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rcc_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_count      (q_count),
    .push         (q_push),
    .push_data    (q_din)
  );

  rcc_queue #(
    .WIDTH (TASK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .count (q_count)
  );

  rcc_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .coef_rows  (coef_rows),
    .task_avail (q_count != '0),
    .task_data  (conv_task_t'(q_dout)),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |-> q_count != QC_W'(QUEUE_DEPTH))
    else $error("task queue overflow");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("task queue underflow");

  a_credit_stall: assert property (@(posedge clk) disable iff (rst)
    q_count == QC_W'(QUEUE_DEPTH) |-> in_stall)
    else $error("input taken while the task queue is full");

endmodule
`default_nettype wire
